// File: rtl/twvcs_pkg.sv
package twvcs_pkg;

	// input word: one timing tick
	typedef struct packed {
		logic        send_enable;
		logic [2:0]  last_index;
		logic [15:0] word_zero;
		logic [15:0] word_one;
		logic [15:0] word_two;
		logic [15:0] word_three;
		logic [15:0] word_four;
	} in_item_t;

	// result word: line levels after the tick
	typedef struct packed {
		logic scl_level;
		logic sda_level;
		logic sequence_done;
	} out_item_t;

	// timing registers
	typedef struct packed {
		logic [7:0] short_high_ticks;
		logic [7:0] short_end_ticks;
		logic [7:0] long_high_ticks;
		logic [7:0] long_end_ticks;
		logic [7:0] pause_high_ticks;
		logic [7:0] pause_low_ticks;
		logic [7:0] stop_hold_ticks;
	} cfg_t;

	typedef enum logic [2:0] {
		CFG_SHORT_HIGH = 3'd0,
		CFG_SHORT_END  = 3'd1,
		CFG_LONG_HIGH  = 3'd2,
		CFG_LONG_END   = 3'd3,
		CFG_PAUSE_HIGH = 3'd4,
		CFG_PAUSE_LOW  = 3'd5,
		CFG_STOP_HOLD  = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_PREAMBLE = 3'd0,
		PH_BIT_OUT  = 3'd1,
		PH_CLK_HI_A = 3'd2,
		PH_CLK_HI_B = 3'd3,
		PH_PAUSE_LO = 3'd4,
		PH_STOP     = 3'd5
	} phase_t;

	localparam logic [7:0] SHORT_HIGH_RST = 8'd5;
	localparam logic [7:0] SHORT_END_RST  = 8'd35;
	localparam logic [7:0] LONG_HIGH_RST  = 8'd30;
	localparam logic [7:0] LONG_END_RST   = 8'd60;
	localparam logic [7:0] PAUSE_HIGH_RST = 8'd5;
	localparam logic [7:0] PAUSE_LOW_RST  = 8'd30;
	localparam logic [7:0] STOP_HOLD_RST  = 8'd5;

	localparam logic [3:0] BIT_PAUSE = 4'd8;
	localparam logic [3:0] BIT_LAST  = 4'd15;

endpackage

// File: rtl/two_wire_voice_command_sender.sv
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    in_data   (in_item_t, one timing tick)
// out       output     out_valid / out_stall  out_data  (out_item_t, line levels)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data (8-bit timing regs)
//
// each word is one sequencer step; one word per cycle sustained while out_stall does not hold the result
// a word passes through the input register, then the sequencer step into the result register
// arst_n clears the sequencer to preamble with both lines high and restores
// the timing registers to their defaults; cfg_ready is always high
// out_stall on a valid result holds the result register and a full input register; in_stall rises with it
module two_wire_voice_command_sender (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  twvcs_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output twvcs_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [7:0]           cfg_data
);
	import twvcs_pkg::*;

	// input register
	logic      valid_s1;
	in_item_t  item_s1;
	// result register
	logic      out_valid_q;
	out_item_t out_q;
	// timing registers
	cfg_t      cfg_q;

	out_item_t step_res;
	logic      advance;
	logic      fire;

	// result register is free, or is being emptied this cycle
	assign advance  = !out_valid_q || !out_stall;
	// tick in the input register goes through the sequencer
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// sequencer state advances once per tick word
	twvcs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.cfg    (cfg_q),
		.item   (item_s1),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= step_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// register writes; unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_high_ticks <= SHORT_HIGH_RST;
			cfg_q.short_end_ticks  <= SHORT_END_RST;
			cfg_q.long_high_ticks  <= LONG_HIGH_RST;
			cfg_q.long_end_ticks   <= LONG_END_RST;
			cfg_q.pause_high_ticks <= PAUSE_HIGH_RST;
			cfg_q.pause_low_ticks  <= PAUSE_LOW_RST;
			cfg_q.stop_hold_ticks  <= STOP_HOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SHORT_HIGH: cfg_q.short_high_ticks <= cfg_data;
				CFG_SHORT_END:  cfg_q.short_end_ticks  <= cfg_data;
				CFG_LONG_HIGH:  cfg_q.long_high_ticks  <= cfg_data;
				CFG_LONG_END:   cfg_q.long_end_ticks   <= cfg_data;
				CFG_PAUSE_HIGH: cfg_q.pause_high_ticks <= cfg_data;
				CFG_PAUSE_LOW:  cfg_q.pause_low_ticks  <= cfg_data;
				CFG_STOP_HOLD:  cfg_q.stop_hold_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/twvcs_seq.sv
module twvcs_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  twvcs_pkg::cfg_t     cfg,
	input  twvcs_pkg::in_item_t item,
	output twvcs_pkg::out_item_t res
);
	import twvcs_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  tick_q, tick_d;
	logic [2:0]  word_idx_q, word_idx_d;
	logic [3:0]  bit_idx_q, bit_idx_d;
	logic [15:0] shift_q, shift_d;
	logic        pause_done_q, pause_done_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        done_d;

	logic [15:0] word_sel;
	logic        long_pre;
	logic [7:0]  pre_high, pre_end;
	logic [7:0]  tick_inc;
	logic        pre_high_run, pre_low_run;
	logic        in_pause_hi;
	logic        pause_hi_end, pause_lo_end, stop_end;

	always_comb begin
		unique case (word_idx_q)
			3'd0:    word_sel = item.word_zero;
			3'd1:    word_sel = item.word_one;
			3'd2:    word_sel = item.word_two;
			3'd3:    word_sel = item.word_three;
			3'd4:    word_sel = item.word_four;
			default: word_sel = 16'h0000;
		endcase
	end

	assign long_pre     = (item.last_index > 3'd1) && (word_idx_q == 3'd3 || word_idx_q == 3'd5);
	assign pre_high     = long_pre ? cfg.long_high_ticks : cfg.short_high_ticks;
	assign pre_end      = long_pre ? cfg.long_end_ticks : cfg.short_end_ticks;
	assign tick_inc     = tick_q + 8'd1;
	assign pre_high_run = tick_q < pre_high;
	assign pre_low_run  = tick_q < pre_end;
	assign in_pause_hi  = (bit_idx_q == BIT_PAUSE) && !pause_done_q;
	assign pause_hi_end = tick_inc > cfg.pause_high_ticks;
	assign pause_lo_end = tick_inc > cfg.pause_low_ticks;
	assign stop_end     = tick_inc > cfg.stop_hold_ticks;

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (item.send_enable) begin
			unique case (phase_q)
				PH_PREAMBLE: if (!pre_high_run && !pre_low_run) phase_d = PH_BIT_OUT;
				PH_BIT_OUT: begin
					if (in_pause_hi) begin
						if (pause_hi_end) phase_d = PH_PAUSE_LO;
					end else if (bit_idx_q < BIT_LAST) begin
						phase_d = PH_CLK_HI_A;
					end else begin
						phase_d = PH_STOP;
					end
				end
				PH_CLK_HI_A, PH_CLK_HI_B: phase_d = PH_BIT_OUT;
				PH_PAUSE_LO: if (pause_lo_end) phase_d = PH_BIT_OUT;
				PH_STOP:     if (stop_end) phase_d = PH_PREAMBLE;
				default:     phase_d = PH_PREAMBLE;
			endcase
		end
	end

	// counters, shifter and line levels
	always_comb begin
		tick_d       = tick_q;
		word_idx_d   = word_idx_q;
		bit_idx_d    = bit_idx_q;
		shift_d      = shift_q;
		pause_done_d = pause_done_q;
		scl_d        = scl_q;
		sda_d        = sda_q;
		done_d       = 1'b0;
		if (!item.send_enable) begin
			scl_d = 1'b1;
			sda_d = 1'b1;
		end else begin
			unique case (phase_q)
				PH_PREAMBLE: begin
					shift_d      = {word_sel[7:0], word_sel[15:8]};
					bit_idx_d    = '0;
					pause_done_d = 1'b0;
					if (pre_high_run) begin
						scl_d  = 1'b1;
						tick_d = tick_inc;
					end else if (pre_low_run) begin
						scl_d  = 1'b0;
						tick_d = tick_inc;
					end else begin
						tick_d = '0;
					end
				end
				PH_BIT_OUT: begin
					if (in_pause_hi) begin
						scl_d  = 1'b1;
						sda_d  = 1'b1;
						tick_d = pause_hi_end ? 8'd0 : tick_inc;
					end else begin
						scl_d   = 1'b0;
						sda_d   = shift_q[0];
						shift_d = {1'b0, shift_q[15:1]};
						if (bit_idx_q < BIT_LAST) bit_idx_d = bit_idx_q + 4'd1;
					end
				end
				PH_CLK_HI_A, PH_CLK_HI_B: scl_d = 1'b1;
				PH_PAUSE_LO: begin
					scl_d  = 1'b0;
					tick_d = pause_lo_end ? 8'd0 : tick_inc;
					if (pause_lo_end) pause_done_d = 1'b1;
				end
				PH_STOP: begin
					scl_d = 1'b1;
					if (tick_q != 8'd0) sda_d = 1'b1;
					tick_d = stop_end ? 8'd0 : tick_inc;
					if (stop_end) begin
						if (word_idx_q < item.last_index) begin
							word_idx_d = word_idx_q + 3'd1;
						end else begin
							word_idx_d = '0;
							done_d     = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_PREAMBLE;
			tick_q       <= '0;
			word_idx_q   <= '0;
			bit_idx_q    <= '0;
			shift_q      <= '0;
			pause_done_q <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
		end else if (step) begin
			phase_q      <= phase_d;
			tick_q       <= tick_d;
			word_idx_q   <= word_idx_d;
			bit_idx_q    <= bit_idx_d;
			shift_q      <= shift_d;
			pause_done_q <= pause_done_d;
			scl_q        <= scl_d;
			sda_q        <= sda_d;
		end
	end

	assign res.scl_level     = scl_d;
	assign res.sda_level     = sda_d;
	assign res.sequence_done = done_d;

endmodule

// File: rtl/twvcs_check.sv
module twvcs_check (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input twvcs_pkg::out_item_t out_data,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);
	import twvcs_pkg::*;

	// a held result word does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// input only backs up when the result side is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// end of sequence comes out of the stop hold, with the clock line high
	a_done_scl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sequence_done |-> out_data.scl_level)
		else $error("sequence done with clock line low");

	// register port never pushes back
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write refused");

endmodule

bind two_wire_voice_command_sender twvcs_check u_twvcs_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

// File: test/two_wire_voice_command_sender_tb.sv
`timescale 1ns / 100ps

module two_wire_voice_command_sender_tb;
	import twvcs_pkg::*;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// tick channel into the sender
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;

	// line level channel out of the sender
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	// timing register write channel
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = CFG_SHORT_HIGH;
	logic [7:0] cfg_data = 8'd0;

	two_wire_voice_command_sender DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// shadow of the sender: timing registers and sequencer state
	// ------------------------------------------------------------------
	cfg_t timing = '{SHORT_HIGH_RST, SHORT_END_RST, LONG_HIGH_RST, LONG_END_RST,
		PAUSE_HIGH_RST, PAUSE_LOW_RST, STOP_HOLD_RST};

	logic [2:0]  seq_phase  = PH_PREAMBLE;
	logic [7:0]  seq_ticks  = 8'd0;
	logic [2:0]  seq_word   = 3'd0;
	logic [3:0]  seq_bit    = 4'd0;
	logic [15:0] seq_shift  = 16'd0;
	logic        seq_paused = 1'b0;
	logic        seq_scl    = 1'b1;
	logic        seq_sda    = 1'b1;

	// advance the shadow sequencer by one tick and return the line levels
	function automatic out_item_t next_line_levels(in_item_t t);
		out_item_t lv;
		logic [15:0] w;
		logic lng;
		logic [7:0] hi_lim;
		logic [7:0] end_lim;
		lv = '0;
		if (!t.send_enable) begin
			// disabled: lines idle high, nothing moves
			seq_scl = 1'b1;
			seq_sda = 1'b1;
		end else begin
			case (seq_phase)
				PH_PREAMBLE: begin
					// positions past four read as zero
					case (seq_word)
						3'd0: w = t.word_zero;
						3'd1: w = t.word_one;
						3'd2: w = t.word_two;
						3'd3: w = t.word_three;
						3'd4: w = t.word_four;
						default: w = 16'd0;
					endcase
					// words 3 and 5 get the long preamble once the list is long enough
					lng = (t.last_index > 3'd1) && (seq_word == 3'd3 || seq_word == 3'd5);
					hi_lim = lng ? timing.long_high_ticks : timing.short_high_ticks;
					end_lim = lng ? timing.long_end_ticks : timing.short_end_ticks;
					seq_shift = {w[7:0], w[15:8]};
					seq_bit = 4'd0;
					seq_paused = 1'b0;
					if (seq_ticks < hi_lim) begin
						seq_scl = 1'b1;
						seq_ticks++;
					end else if (seq_ticks < end_lim) begin
						seq_scl = 1'b0;
						seq_ticks++;
					end else begin
						seq_ticks = 8'd0;
						seq_phase = PH_BIT_OUT;
					end
				end
				PH_BIT_OUT: begin
					if (seq_bit == BIT_PAUSE && !seq_paused) begin
						// high part of the mid-word pause, counter wraps
						seq_scl = 1'b1;
						seq_sda = 1'b1;
						seq_ticks++;
						if (seq_ticks > timing.pause_high_ticks) begin
							seq_phase = PH_PAUSE_LO;
							seq_ticks = 8'd0;
						end
					end else begin
						seq_scl = 1'b0;
						seq_sda = seq_shift[0];
						seq_shift = seq_shift >> 1;
						if (seq_bit < BIT_LAST) begin
							seq_bit++;
							seq_phase = PH_CLK_HI_A;
						end else begin
							seq_phase = PH_STOP;
						end
					end
				end
				PH_CLK_HI_A, PH_CLK_HI_B: begin
					seq_scl = 1'b1;
					seq_phase = PH_BIT_OUT;
				end
				PH_PAUSE_LO: begin
					seq_scl = 1'b0;
					seq_ticks++;
					if (seq_ticks > timing.pause_low_ticks) begin
						seq_ticks = 8'd0;
						seq_phase = PH_BIT_OUT;
						seq_paused = 1'b1;
					end
				end
				PH_STOP: begin
					// sda keeps the last bit on the first stop tick only
					seq_scl = 1'b1;
					if (seq_ticks != 8'd0)
						seq_sda = 1'b1;
					seq_ticks++;
					if (seq_ticks > timing.stop_hold_ticks) begin
						seq_ticks = 8'd0;
						seq_phase = PH_PREAMBLE;
						// a lowered index mid-send ends the list here
						if (seq_word < t.last_index) begin
							seq_word++;
						end else begin
							seq_word = 3'd0;
							lv.sequence_done = 1'b1;
						end
					end
				end
				default: seq_phase = PH_PREAMBLE;
			endcase
		end
		lv.scl_level = seq_scl;
		lv.sda_level = seq_sda;
		return lv;
	endfunction

	// ------------------------------------------------------------------
	// bookkeeping
	// ------------------------------------------------------------------
	in_item_t  ticks_pending[$];
	out_item_t levels_due[$];
	int ticks_queued = 0;
	int ticks_taken = 0;
	int results_seen = 0;
	int mismatches = 0;

	// mostly short gaps, a few long ones, and calm stretches with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// driver: hands out ticks from the pending queue
	// ------------------------------------------------------------------
	int in_gap = 0;
	int in_calm = 0;
	out_item_t predicted;

	always @(posedge clk) begin
		if (arst_n) begin
			// word taken at this edge: predict its line levels
			if (in_valid && !in_stall) begin
				predicted = next_line_levels(in_data);
				levels_due.push_back(predicted);
				ticks_taken++;
			end
			// a stalled word stays put
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (ticks_pending.size() != 0) begin
					in_data <= ticks_pending.pop_front();
					in_valid <= 1'b1;
					in_gap = pick_gap(in_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks line levels and throttles the output with stall
	// ------------------------------------------------------------------
	int stall_left = 0;
	int out_calm = 0;
	out_item_t want;

	task automatic flag_field(input string field, input logic exp_bit, input logic got_bit);
		mismatches++;
		if (mismatches <= 10)
			$display("result %0d: %s expected %0b, got %0b", results_seen, field,
				exp_bit, got_bit);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (levels_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: word with nothing expected (%b)", results_seen,
							out_data);
				end else begin
					want = levels_due.pop_front();
					if (out_data.scl_level !== want.scl_level)
						flag_field("scl_level", want.scl_level, out_data.scl_level);
					if (out_data.sda_level !== want.sda_level)
						flag_field("sda_level", want.sda_level, out_data.sda_level);
					if (out_data.sequence_done !== want.sequence_done)
						flag_field("sequence_done", want.sequence_done, out_data.sequence_done);
				end
				results_seen++;
			end
			// stall runs independent of valid so it lands on every phase
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 2) == 0)
					stall_left = pick_gap(out_calm);
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_tick(input in_item_t t);
		ticks_pending.push_back(t);
		ticks_queued++;
	endtask

	function automatic logic [15:0] rand_word();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	// mostly whole sends with the words held steady; some disabled
	// stretches, index changes mid-send and word noise on top
	task automatic queue_sends(input int count);
		in_item_t t;
		int n;
		int hold;
		int r;
		n = 0;
		while (n < count) begin
			t.send_enable = 1'b1;
			t.last_index = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) :
				3'($urandom_range(5, 7));
			t.word_zero = rand_word();
			t.word_one = rand_word();
			t.word_two = rand_word();
			t.word_three = rand_word();
			t.word_four = rand_word();
			hold = $urandom_range(20, 250);
			for (int k = 0; k < hold && n < count; k++) begin
				r = $urandom_range(0, 199);
				if (!t.send_enable)
					t.send_enable = ($urandom_range(0, 3) == 0);
				else
					t.send_enable = (r >= 3);
				// index lowered or raised while a send is running
				if (r == 4)
					t.last_index = 3'($urandom_range(0, 7));
				// word changes under a running send
				if (r == 5)
					t.word_zero = rand_word();
				if (r == 6)
					t.word_three = rand_word();
				push_tick(t);
				n++;
			end
		end
	endtask

	// register writes only once nothing is in flight
	task automatic write_timing_reg(input cfg_reg_t idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SHORT_HIGH: timing.short_high_ticks = val;
			CFG_SHORT_END:  timing.short_end_ticks = val;
			CFG_LONG_HIGH:  timing.long_high_ticks = val;
			CFG_LONG_END:   timing.long_end_ticks = val;
			CFG_PAUSE_HIGH: timing.pause_high_ticks = val;
			CFG_PAUSE_LOW:  timing.pause_low_ticks = val;
			CFG_STOP_HOLD:  timing.stop_hold_ticks = val;
			default: ;
		endcase
	endtask

	task automatic set_timing(input cfg_t c);
		write_timing_reg(CFG_SHORT_HIGH, c.short_high_ticks);
		write_timing_reg(CFG_SHORT_END, c.short_end_ticks);
		write_timing_reg(CFG_LONG_HIGH, c.long_high_ticks);
		write_timing_reg(CFG_LONG_END, c.long_end_ticks);
		write_timing_reg(CFG_PAUSE_HIGH, c.pause_high_ticks);
		write_timing_reg(CFG_PAUSE_LOW, c.pause_low_ticks);
		write_timing_reg(CFG_STOP_HOLD, c.stop_hold_ticks);
	endtask

	function automatic cfg_t rand_timing(input int top);
		cfg_t c;
		c.short_high_ticks = 8'($urandom_range(0, top));
		c.short_end_ticks = 8'($urandom_range(0, top));
		c.long_high_ticks = 8'($urandom_range(0, top));
		c.long_end_ticks = 8'($urandom_range(0, top));
		c.pause_high_ticks = 8'($urandom_range(0, top));
		c.pause_low_ticks = 8'($urandom_range(0, top));
		c.stop_hold_ticks = 8'($urandom_range(0, top));
		return c;
	endfunction

	// wait for every tick to be taken and every result checked,
	// then let the two-stage pipeline settle
	task automatic drain();
		while (ticks_taken != ticks_queued || levels_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	cfg_t c;
	in_item_t d;

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset timing first
		queue_sends(120);
		drain();

		// all registers at zero: shortest possible preamble, pause and stop
		set_timing('0);
		d = '0;
		d.last_index = 3'd7;
		d.word_zero = 16'hFFFF;
		d.word_one = 16'hFFFF;
		d.word_two = 16'hFFFF;
		d.word_three = 16'hFFFF;
		d.word_four = 16'hFFFF;
		push_tick(d);
		push_tick('0);
		d = '0;
		d.send_enable = 1'b1;
		d.word_zero = 16'hA5C3;
		d.word_one = 16'h5A3C;
		for (int k = 0; k < 23; k++)
			push_tick(d);
		queue_sends(150);
		drain();

		// small random timings give lots of finished sends
		repeat (3) begin
			set_timing(rand_timing(3));
			queue_sends(110);
			drain();
		end

		// preamble extremes: short high at max, long end at max
		c = rand_timing(2);
		c.short_high_ticks = 8'd255;
		c.short_end_ticks = 8'd0;
		c.long_high_ticks = 8'd0;
		c.long_end_ticks = 8'd255;
		set_timing(c);
		queue_sends(200);
		drain();

		// pause high limit at max: counter wraps, sender sits in the pause
		c = rand_timing(2);
		c.pause_high_ticks = 8'd255;
		set_timing(c);
		queue_sends(250);
		drain();

		// pause low limit at max
		c = rand_timing(2);
		c.pause_low_ticks = 8'd255;
		set_timing(c);
		queue_sends(250);
		drain();

		// stop hold limit at max
		c = rand_timing(2);
		c.stop_hold_ticks = 8'd255;
		set_timing(c);
		queue_sends(250);
		drain();

		// moderate mixed timings
		set_timing(rand_timing(40));
		queue_sends(200);
		drain();

		set_timing(rand_timing(2));
		queue_sends(150);
		drain();

		if (mismatches == 0 && levels_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#6000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
